@@ src/fac_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fac_pkg
// Shared types and constants for the frustum box cull core.
// ----------------------------------------------------------------------------
package fac_pkg;

  localparam int DATA_W    = 32;              // Q16.16 element / coordinate
  localparam int FRAC_BITS = 16;
  localparam int NORM_W    = DATA_W + 1;      // exact sum/difference of two elements
  localparam int PROD_W    = NORM_W + DATA_W; // exact product
  localparam int ACC_W     = PROD_W + 3;      // three products plus offset, no overflow

  localparam int PLANE_COUNT = 6;
  localparam int PLANE_W     = $clog2(PLANE_COUNT);
  localparam int AXES        = 3;

  // stream widths, padded to whole bytes
  localparam int IDX_W       = 4;
  localparam int IN_RAW_W    = IDX_W + DATA_W + 6 * DATA_W;
  localparam int IN_DATA_W   = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_DATA_W  = 8;

  typedef logic signed [DATA_W-1:0] fac_word_t;

  // request kinds carried on tuser
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEST = 1'b1;

  // column 3 of the clip matrix holds the plane offsets
  localparam logic [1:0] COL_OFFSET = 2'd3;
  localparam logic [1:0] ROW_W_IDX  = 2'd3;
  localparam logic [PLANE_W-1:0] LAST_PLANE = PLANE_W'(PLANE_COUNT - 1);

  // offset term goes through the multiplier scaled by 2^FRAC_BITS
  localparam fac_word_t UNIT_Q = DATA_W'(1) << FRAC_BITS;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_RUN    = 3'b010,
    ST_FINISH = 3'b100
  } fac_state_t;

  typedef struct packed {
    logic       start;  // new test accepted, clear the cull flag
    logic       issue;  // one term enters the pipeline
    logic [1:0] col;    // matrix column (axis, or offset column)
    logic [1:0] row;    // matrix row paired with row 3
    logic       minus;  // row 3 minus row, else plus
    logic       first;  // first term of a plane
    logic       last;   // last term of a plane
  } fac_ctrl_t;

endpackage

@@ src/fac_matrix.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fac_matrix
// Clip matrix store; row 3 kept apart so both plane operands read at once.
// ----------------------------------------------------------------------------
module fac_matrix (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [3:0]          wr_idx,   // column*4 + row
  input  fac_pkg::fac_word_t  wr_data,
  input  logic [1:0]          rd_col,
  input  logic [1:0]          rd_row,   // 0..2
  output fac_pkg::fac_word_t  rd_w,     // element (col, 3)
  output fac_pkg::fac_word_t  rd_r      // element (col, row)
);
  import fac_pkg::*;

  fac_word_t w_r [4];
  fac_word_t e_r [4][3];

  logic [1:0] wr_col;
  logic [1:0] wr_row;

  assign wr_col = wr_idx[3:2];
  assign wr_row = wr_idx[1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < 4; c++) begin
        w_r[c] <= '0;
        for (int r = 0; r < 3; r++) begin
          e_r[c][r] <= '0;
        end
      end
    end else if (wr_en) begin
      if (wr_row == ROW_W_IDX) begin
        w_r[wr_col] <= wr_data;
      end else begin
        e_r[wr_col][wr_row] <= wr_data;
      end
    end
  end

  assign rd_w = w_r[rd_col];
  assign rd_r = e_r[rd_col][rd_row];

endmodule

@@ src/fac_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fac_seq
// Sequencer: walks six planes by four terms through the shared MAC.
// ----------------------------------------------------------------------------
module fac_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,     // test request accepted
  input  logic               mac_busy,
  input  logic               out_free,
  output logic               in_ready,
  output logic               finish,    // load result register
  output fac_pkg::fac_ctrl_t ctrl
);
  import fac_pkg::*;

  fac_state_t         state_r, state_nxt;
  logic [PLANE_W-1:0] plane_r, plane_nxt;
  logic [1:0]         col_r, col_nxt;

  always_comb begin
    state_nxt  = state_r;
    plane_nxt  = plane_r;
    col_nxt    = col_r;
    finish     = 1'b0;
    ctrl       = '0;
    ctrl.start = start;
    ctrl.col   = col_r;
    ctrl.row   = plane_r[PLANE_W-1:1];
    ctrl.minus = plane_r[0];
    ctrl.first = (col_r == 2'd0);
    ctrl.last  = (col_r == COL_OFFSET);
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_RUN;
          plane_nxt = '0;
          col_nxt   = '0;
        end
      end
      ST_RUN: begin
        ctrl.issue = 1'b1;
        col_nxt    = col_r + 2'd1;
        if (col_r == COL_OFFSET) begin
          plane_nxt = plane_r + PLANE_W'(1);
          if (plane_r == LAST_PLANE) begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (!mac_busy && out_free) begin
          finish    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      plane_r <= '0;
      col_r   <= '0;
    end else begin
      state_r <= state_nxt;
      plane_r <= plane_nxt;
      col_r   <= col_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

endmodule

@@ src/fac_mac.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fac_mac
// Shared plane unit: form normal, pick vertex, multiply, accumulate, sign test.
// ----------------------------------------------------------------------------
module fac_mac (
  input  logic               clk,
  input  logic               rst_n,
  input  fac_pkg::fac_ctrl_t ctrl,
  input  fac_pkg::fac_word_t rd_w,
  input  fac_pkg::fac_word_t rd_r,
  input  fac_pkg::fac_word_t box_min [3],
  input  fac_pkg::fac_word_t box_max [3],
  output logic               busy,
  output logic               visible
);
  import fac_pkg::*;

  // stage 1: normal component (or offset) and its multiplicand
  logic signed [NORM_W-1:0] n_nxt, n_r;
  fac_word_t                b_nxt, b_r;
  logic                     v1_r, first1_r, last1_r;
  // stage 2: product
  logic signed [PROD_W-1:0] prod_nxt, prod_r;
  logic                     v2_r, first2_r, last2_r;
  // stage 3: accumulator
  logic signed [ACC_W-1:0]  acc_nxt, acc_r;
  logic                     cull_r;

  always_comb begin
    if (ctrl.minus) begin
      n_nxt = NORM_W'(rd_w) - NORM_W'(rd_r);
    end else begin
      n_nxt = NORM_W'(rd_w) + NORM_W'(rd_r);
    end
    // positive vertex: max corner where the normal is >= 0
    if (ctrl.col == COL_OFFSET) begin
      b_nxt = UNIT_Q;
    end else if (n_nxt[NORM_W-1]) begin
      b_nxt = box_min[ctrl.col];
    end else begin
      b_nxt = box_max[ctrl.col];
    end
  end

  assign prod_nxt = PROD_W'(n_r) * PROD_W'(b_r);
  assign acc_nxt  = (first2_r ? ACC_W'(0) : acc_r) + ACC_W'(prod_r);

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    b_r    <= b_nxt;
    prod_r <= prod_nxt;
    if (v2_r) begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      first1_r <= 1'b0;
      last1_r  <= 1'b0;
      v2_r     <= 1'b0;
      first2_r <= 1'b0;
      last2_r  <= 1'b0;
      cull_r   <= 1'b0;
    end else begin
      v1_r     <= ctrl.issue;
      first1_r <= ctrl.first;
      last1_r  <= ctrl.last;
      v2_r     <= v1_r;
      first2_r <= first1_r;
      last2_r  <= last1_r;
      if (ctrl.start) begin
        cull_r <= 1'b0;
      end else if (v2_r && last2_r && acc_nxt[ACC_W-1]) begin
        cull_r <= 1'b1;
      end
    end
  end

  assign busy    = v1_r | v2_r;
  assign visible = ~cull_r;

endmodule

@@ src/frustum_aabb_cull_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_aabb_cull_core
// View-frustum cull of axis-aligned boxes against a loaded 4x4 clip matrix.
// ----------------------------------------------------------------------------
// Load request: written to the clip matrix on accept, no result; loads may stream back to back.
// Test request: result registered once the MAC has drained and the output is free;
//   next request taken only after that, so tests run one at a time through the single 33x32
//   multiplier issuing 24 terms (6 planes x 3 axes + offset).
// Result register frees the input side: a pending result does not stall loads.
// Reset (rst_n low, synchronous): clip matrix zeroed (all boxes visible),
//   sequencer idle, output empty.
// ----------------------------------------------------------------------------
module frustum_aabb_cull_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // tdata, low bit up: element_index[3:0], element_value[31:0],
  //   box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
  //   (32 bits each), zero pad
  input  logic [fac_pkg::IN_DATA_W-1:0]    in_tdata,
  // tuser: opcode (0 load element, 1 test box)
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // tdata, low bit up: visible, zero pad
  output logic [fac_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import fac_pkg::*;

  // field offsets within in_tdata
  localparam int VAL_LO = IDX_W;
  localparam int BOX_LO = IDX_W + DATA_W;

  logic       in_acc;
  logic       do_load;
  logic       do_test;

  fac_word_t  box_min_r [3];
  fac_word_t  box_max_r [3];

  fac_ctrl_t  ctrl;
  fac_word_t  rd_w;
  fac_word_t  rd_r;
  logic       mac_busy;
  logic       mac_visible;
  logic       finish;
  logic       out_free;

  logic       out_tvalid_r;
  logic       visible_r;

  assign in_acc  = in_tvalid & in_tready;
  assign do_load = in_acc & (in_tuser == OP_LOAD);
  assign do_test = in_acc & (in_tuser == OP_TEST);

  // box corners held for the whole test
  always_ff @(posedge clk) begin
    if (do_test) begin
      for (int a = 0; a < AXES; a++) begin
        box_min_r[a] <= in_tdata[BOX_LO + a*DATA_W +: DATA_W];
        box_max_r[a] <= in_tdata[BOX_LO + (AXES + a)*DATA_W +: DATA_W];
      end
    end
  end

  fac_matrix u_matrix (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (do_load),
    .wr_idx  (in_tdata[IDX_W-1:0]),
    .wr_data (in_tdata[VAL_LO +: DATA_W]),
    .rd_col  (ctrl.col),
    .rd_row  (ctrl.row),
    .rd_w    (rd_w),
    .rd_r    (rd_r)
  );

  fac_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (do_test),
    .mac_busy (mac_busy),
    .out_free (out_free),
    .in_ready (in_tready),
    .finish   (finish),
    .ctrl     (ctrl)
  );

  fac_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .rd_w    (rd_w),
    .rd_r    (rd_r),
    .box_min (box_min_r),
    .box_max (box_max_r),
    .busy    (mac_busy),
    .visible (mac_visible)
  );

  // output register: empty or being taken this cycle
  assign out_free = ~out_tvalid_r | out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (finish) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      visible_r <= mac_visible;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_DATA_W'(visible_r);

endmodule

@@ src/fac_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fac_checker
// Port-level checks for the cull core, bound to the top level.
// ----------------------------------------------------------------------------
module fac_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [fac_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import fac_pkg::*;

  logic test_acc;
  logic load_acc;

  assign test_acc = in_tvalid & in_tready & (in_tuser == OP_TEST);
  assign load_acc = in_tvalid & in_tready & (in_tuser == OP_LOAD);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed while stalled");

  // a test keeps the input closed while the planes run
  a_test_busy: assert property (@(posedge clk) disable iff (!rst_n)
    test_acc |=> !in_tready ##1 !in_tready)
    else $error("input reopened during a test");

  // loads never stall the input
  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    load_acc |=> in_tready)
    else $error("input closed after a load");

  // input reopens only together with a fresh result
  a_reopen_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_tready) |-> out_tvalid)
    else $error("test finished without a result");

endmodule

bind frustum_aabb_cull_core fac_checker u_fac_checker (.*);
